// ----- hdl/trw_pkg.sv -----
`timescale 1ns / 1ps

package trw_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int RES_W      = 32;
  localparam int C_W        = 23;
  localparam int W_W        = FRAC_BITS + 1;
  localparam int DIV_STEPS  = 31;
  localparam int SQRT_STEPS = 16;

  localparam logic [1:0]      TUKEY_C_ADDR = 2'd0;

  localparam logic [C_W-1:0]  C_RESET     = C_W'(3 << FRAC_BITS);
  localparam logic [W_W-1:0]  W_ONE       = W_W'(1 << FRAC_BITS);
  localparam logic [30:0]     Q30_ONE     = 31'h4000_0000;
  localparam logic [33:0]     THREE_Q30   = 34'h0_C000_0000;
  localparam logic [31:0]     THIRD_RECIP = 32'hAAAA_AAAB;

  typedef struct packed {
    logic        valid;
    logic        zero;
    logic        band;
    logic [31:0] r;
    logic [31:0] d;
    logic [30:0] n;
  } div_t;

  typedef struct packed {
    logic        valid;
    logic        zero;
    logic [17:0] rem;
    logic [15:0] root;
    logic [31:0] qv;
  } sq_t;

endpackage

// ----- hdl/trw_div_cell.sv -----
`timescale 1ns / 1ps

module trw_div_cell (
  input  logic         clk,
  input  logic         rst,
  input  trw_pkg::div_t din,
  output trw_pkg::div_t dout
);
  import trw_pkg::*;

  logic [32:0] r2;
  logic [32:0] diff;
  logic        take;

  assign r2   = {din.r, din.n[30]};
  assign diff = r2 - {1'b0, din.d};
  assign take = r2 >= {1'b0, din.d};

  always_ff @(posedge clk) begin
    dout.zero <= din.zero;
    dout.band <= din.band;
    dout.d    <= din.d;
    dout.r    <= take ? diff[31:0] : r2[31:0];
    dout.n    <= {din.n[29:0], take};
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

endmodule

// ----- hdl/trw_sqrt_cell.sv -----
`timescale 1ns / 1ps

module trw_sqrt_cell (
  input  logic        clk,
  input  logic        rst,
  input  trw_pkg::sq_t din,
  output trw_pkg::sq_t dout
);
  import trw_pkg::*;

  logic [19:0] rem4;
  logic [19:0] trial;
  logic [19:0] diff;
  logic        take;

  assign rem4  = {din.rem, din.qv[31:30]};
  assign trial = {2'b00, din.root, 2'b01};
  assign diff  = rem4 - trial;
  assign take  = rem4 >= trial;

  always_ff @(posedge clk) begin
    dout.zero <= din.zero;
    dout.rem  <= take ? diff[17:0] : rem4[17:0];
    dout.root <= {din.root[14:0], take};
    dout.qv   <= {din.qv[29:0], 2'b00};
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

endmodule

// ----- hdl/tukey_robust_weight.sv -----
`timescale 1ns / 1ps

// Tukey biweight weight for one signed Q16.16 residual per clock. The block
// never raises busy, so a word may be started in every cycle; its weight
// appears with done exactly 53 cycles later (one input register, 31 divider
// cells, four multiply and scale stages, 16 square-root cells and the output
// register), and the receiver must take it in that cycle. The tuning constant
// c lies at address 0 and is to be written only while no word is in flight.
module tukey_robust_weight (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [trw_pkg::RES_W-1:0] residual,
  output logic                          done,
  output logic [trw_pkg::W_W-1:0]       weight,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import trw_pkg::*;

  logic [C_W-1:0] tukey_c;
  logic [31:0]    a;
  logic           band;
  div_t           div_pipe [0:DIV_STEPS];
  sq_t            sq_pipe  [0:SQRT_STEPS];

  logic           m1_valid, m1_zero, m1_band;
  logic [61:0]    m1_prod;
  logic           m2_valid, m2_zero, m2_band;
  logic [31:0]    m2_v;
  logic [61:0]    m2_prod;
  logic           p_valid, p_zero, p_band;
  logic [31:0]    p_x;
  logic           d6_valid, d6_zero, d6_band;
  logic [62:0]    d6_prod;
  logic [33:0]    p_sum;
  logic [29:0]    q6;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = {{(32 - C_W){1'b0}}, tukey_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      tukey_c <= C_RESET;
    end else if (psel && penable && pwrite && paddr == TUKEY_C_ADDR) begin
      tukey_c <= pwdata[C_W-1:0];
    end
  end

  assign a    = residual[RES_W-1] ? (~residual + 32'd1) : residual;
  assign band = a <= {{(32 - C_W){1'b0}}, tukey_c};

  always_ff @(posedge clk) begin
    div_pipe[0].zero <= (a == 32'd0);
    div_pipe[0].band <= band;
    div_pipe[0].r    <= band ? {1'b0, a[31:1]} : {{(32 - C_W){1'b0}}, tukey_c};
    div_pipe[0].d    <= band ? {{(32 - C_W){1'b0}}, tukey_c} : a;
    div_pipe[0].n    <= band ? {a[0], 30'd0} : 31'd0;
    if (rst) begin
      div_pipe[0].valid <= 1'b0;
    end else begin
      div_pipe[0].valid <= start;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    trw_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (div_pipe[i]),
      .dout (div_pipe[i+1])
    );
  end

  assign p_sum = THREE_Q30 - 34'(3 * {2'b00, m2_v}) + {2'b00, m2_prod[61:30]};

  always_ff @(posedge clk) begin
    m1_zero <= div_pipe[DIV_STEPS].zero;
    m1_band <= div_pipe[DIV_STEPS].band;
    m1_prod <= div_pipe[DIV_STEPS].n * div_pipe[DIV_STEPS].n;
    m2_zero <= m1_zero;
    m2_band <= m1_band;
    m2_v    <= m1_prod[61:30];
    m2_prod <= m1_prod[60:30] * m1_prod[60:30];
    p_zero  <= m2_zero;
    p_band  <= m2_band;
    p_x     <= m2_band ? p_sum[31:0] : m2_v;
    d6_zero <= p_zero;
    d6_band <= p_band;
    d6_prod <= p_x[31:1] * THIRD_RECIP;
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      p_valid  <= 1'b0;
      d6_valid <= 1'b0;
    end else begin
      m1_valid <= div_pipe[DIV_STEPS].valid;
      m2_valid <= m1_valid;
      p_valid  <= m2_valid;
      d6_valid <= p_valid;
    end
  end

  assign q6 = d6_prod[62:33];

  assign sq_pipe[0].valid = d6_valid;
  assign sq_pipe[0].zero  = d6_zero;
  assign sq_pipe[0].rem   = 18'd0;
  assign sq_pipe[0].root  = 16'd0;
  assign sq_pipe[0].qv    = d6_band ? {q6, 2'b00} : {2'b00, q6};

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    trw_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (sq_pipe[j]),
      .dout (sq_pipe[j+1])
    );
  end

  always_ff @(posedge clk) begin
    weight <= sq_pipe[SQRT_STEPS].zero ? W_ONE : {1'b0, sq_pipe[SQRT_STEPS].root};
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sq_pipe[SQRT_STEPS].valid;
    end
  end

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    done |-> weight <= W_ONE)
    else $error("weight above one");

  a_full_only_zero: assert property (@(posedge clk) disable iff (rst)
    (done && weight == W_ONE) |-> $past(sq_pipe[SQRT_STEPS].zero))
    else $error("full weight from a nonzero residual");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_pipe[0].valid && !div_pipe[0].zero |-> div_pipe[0].r < div_pipe[0].d)
    else $error("divider started with remainder not below divisor");

  a_band_ratio: assert property (@(posedge clk) disable iff (rst)
    (div_pipe[DIV_STEPS].valid && div_pipe[DIV_STEPS].band) |->
      div_pipe[DIV_STEPS].n <= Q30_ONE)
    else $error("band ratio above one");

endmodule

// ----- dv/trw_checker.sv -----
`timescale 1ns / 1ps

module trw_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [trw_pkg::RES_W-1:0]    residual,
  input  logic                         done,
  input  logic [trw_pkg::W_W-1:0]      weight,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [1:0]                   paddr,
  input  logic [31:0]                  pwdata,
  input  logic                         pready,
  output int                           pending,
  output int                           errors
);
  import trw_pkg::*;

  logic [C_W-1:0] tuning_c;
  logic [W_W-1:0] weights_due[$];

  function automatic logic [W_W-1:0] tukey_weight(input logic [31:0] r,
                                                  input logic [C_W-1:0] c);
    logic [63:0] a, cc, t, u, p, q, s, root, cand;
    a  = r[31] ? (64'h1_0000_0000 - {32'b0, r}) : {32'b0, r};
    cc = {41'b0, c};
    if (a == 0) return W_ONE;
    if (a <= cc) begin
      t = (a << 30) / cc;
      u = (t * t) >> 30;
      p = 64'd3 * (64'd1 << 30) - 64'd3 * u + ((u * u) >> 30);
      q = (p / 64'd6) << (2 * FRAC_BITS - 30);
    end else begin
      s = (cc << 31) / a;
      q = ((s * s) / 64'd6) >> (62 - 2 * FRAC_BITS);
    end
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (cand * cand <= q) root = cand;
    end
    if (root > {47'b0, W_ONE}) root = {47'b0, W_ONE};
    return root[W_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      tuning_c <= C_RESET;
      errors   <= 0;
      pending  <= 0;
      weights_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == TUKEY_C_ADDR)
        tuning_c <= pwdata[C_W-1:0];
      if (start && !busy)
        weights_due.push_back(tukey_weight(residual, tuning_c));
      if (done) begin
        if (weights_due.size() == 0) begin
          $display("%0t: weight %0d with no word outstanding", $time, weight);
          errors <= errors + 1;
        end else if (weights_due[0] !== weight) begin
          $display("%0t: weight expected %0d actual %0d", $time, weights_due[0], weight);
          errors <= errors + 1;
          void'(weights_due.pop_front());
        end else begin
          void'(weights_due.pop_front());
        end
      end
      pending <= weights_due.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import trw_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 3000;
  localparam int SEG_ITEMS    = 167;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 start = 0;
  logic                 busy;
  logic [RES_W-1:0]     residual = '0;
  logic                 done;
  logic [W_W-1:0]       weight;
  logic                 psel = 0, penable = 0, pwrite = 0;
  logic [1:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  int                   pending, errors;
  int                   quiet_cycles = 0;
  logic [C_W-1:0]       cur_c = C_RESET;
  int                   idle_pct = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  tukey_robust_weight dut (.*);

  trw_checker u_checker (.*);

  always @(posedge clk) begin
    if ((start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tukey_robust_weight regression: fail");
      $finish;
    end
  end

  task automatic send_word(input logic [31:0] r);
    while ($urandom_range(99, 0) < idle_pct) begin
      @(negedge clk);
      start <= 0;
    end
    @(negedge clk);
    while (busy) @(negedge clk);
    start <= 1;
    residual <= r;
    @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_c(input logic [C_W-1:0] c);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= TUKEY_C_ADDR; pwdata <= 32'(c);
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    cur_c = c;
  endtask

  function automatic logic [31:0] random_residual(input logic [C_W-1:0] c);
    logic [31:0] m;
    int kind;
    kind = $urandom_range(9, 0);
    if (kind < 4) m = $urandom_range(c, 0);
    else if (kind < 6) m = 32'(c) + $urandom_range(16, 0) - 8;
    else if (kind < 8) return $urandom;
    else m = $urandom_range(1023, 0);
    return $urandom_range(1, 0) ? -m : m;
  endfunction

  initial begin
    logic [C_W-1:0] c_plan[8];
    logic [31:0] directed[$];
    c_plan = '{C_RESET, 23'd1, 23'd4194304, 23'd65536, 23'($urandom_range(4194304, 1)),
               23'd196608, 23'($urandom_range(65536, 1)), 23'd4194303};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    directed = '{32'd0, 32'd1, -32'd1, 32'(C_RESET), -32'(C_RESET), 32'(C_RESET) + 1,
                 -(32'(C_RESET) + 1), 32'(C_RESET) - 1, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h8000_0001, 32'd65536, -32'd65536};
    foreach (directed[i]) send_word(directed[i]);
    drain();

    for (int seg = 0; seg < 8; seg++) begin
      if (seg > 0) write_c(c_plan[seg]);
      idle_pct = (seg % 4 == 1) ? 69 : (seg % 4 == 3) ? 35 : 0;
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if (seg == 2 && i == SEG_ITEMS / 2) begin
          @(negedge clk);
          start <= 0;
          while (pending != 0) @(negedge clk);
        end
        send_word(random_residual(cur_c));
      end
      drain();
    end
    send_word(32'd0);
    drain();

    if (errors == 0) begin
      $display("tukey_robust_weight regression: pass");
    end else begin
      $display("tukey_robust_weight regression: fail");
    end
    $finish;
  end

endmodule
